@@ hw/rtl/wpr_pkg.sv @@
// waveform plot rasterizer: shared constants, queue entry type and overlay functions
// no dependencies; used by all rtl files of the block
`default_nettype none

package wpr_pkg;

  // screen and plot geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int SAMPLE_COUNT  = 128;
  localparam int QUEUE_DEPTH   = 4;
  localparam int OUT_DEPTH     = 4;

  localparam logic [5:0] X_AXIS_ROW     = 6'd55;
  localparam logic [5:0] TOP_ROW        = 6'd15;
  localparam logic [6:0] Y_AXIS_COL     = 7'd8;
  localparam logic [6:0] FIRST_PLOT_COL = 7'd10;
  localparam logic [6:0] PLOT_COLUMNS   = 7'd112;
  localparam logic [6:0] LAST_PLOT_COL  = 7'd121;

  // input operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HSTEP = 2'd0;
  localparam logic [1:0] REG_VGAIN = 2'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       kind;
    logic       flat;
    logic [6:0] col;
    logic [5:0] row;
    logic [5:0] prev_row;
    logic       prev_valid;
    logic [2:0] page;
  } entry_t;

  function automatic logic overlay_pixel(input logic [6:0] x, input logic [5:0] y);
    logic [5:0] dy;
    logic [6:0] hx;
    logic [6:0] wy;
    logic [6:0] wx;
    logic       hit;
    dy  = y - 6'd16;
    hx  = 7'd127 - x;
    wy  = (dy < 6'd2) ? 7'd0 : {1'b0, dy >> 1};
    wx  = (hx < 7'd2) ? 7'd0 : (hx >> 1);
    hit = 1'b0;
    if (y == X_AXIS_ROW) hit = 1'b1;
    if (x == Y_AXIS_COL && y >= TOP_ROW) hit = 1'b1;
    // y axis arrowhead
    if (y >= 6'd16 && y <= 6'd20 &&
        ({1'b0, x} + {1'b0, wy}) >= {1'b0, Y_AXIS_COL} &&
        {1'b0, x} <= ({1'b0, Y_AXIS_COL} + {1'b0, wy}))
      hit = 1'b1;
    // x axis arrowhead
    if (x >= 7'd123 &&
        ({2'b0, y} + {1'b0, wx}) >= {2'b0, X_AXIS_ROW} &&
        {2'b0, y} <= ({2'b0, X_AXIS_ROW} + {1'b0, wx}))
      hit = 1'b1;
    // ticks
    if ((x == 7'd35 || x == 7'd62 || x == 7'd89 || x == 7'd116) &&
        y >= (X_AXIS_ROW - 6'd2) && y <= X_AXIS_ROW)
      hit = 1'b1;
    return hit;
  endfunction

  function automatic logic [7:0] overlay_byte(input logic [2:0] page, input logic [6:0] col);
    logic [7:0] b;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      b[7 - i] = overlay_pixel(col, {page, 3'(i)});
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wpr_fifo.sv @@
// small synchronous fifo with registered pointers and occupancy count
// uses wpr_pkg for default sizes; DEPTH must be a power of two
`default_nettype none

module wpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wpr_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + AW'(1);
      if (pop_ok) rd_ptr <= rd_ptr + AW'(1);
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) slots[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpr_front.sv @@
// front end: takes input transactions, holds config and sample counters,
// scales the sample to a plot row and queues commands; depends on wpr_pkg
`default_nettype none

module wpr_front #(
  parameter int SAMPLE_COUNT = wpr_pkg::SAMPLE_COUNT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [1:0]      operation,
  input  wire logic [7:0]      sample_value,
  input  wire logic [2:0]      page_select,
  input  wire logic [6:0]      column_select,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  output logic                 q_push,
  output wpr_pkg::entry_t      q_entry,
  input  wire logic            q_full
);

  logic [7:0]  horizontal_step;
  logic [7:0]  vertical_gain;
  logic [7:0]  sample_index;
  logic [8:0]  next_due_index;
  logic [6:0]  plot_column;
  logic [5:0]  previous_row;
  logic        previous_valid;

  logic                s1_valid;
  wpr_pkg::cmd_t       s1_kind;
  logic                s1_flat;
  logic [6:0]          s1_col;
  logic [2:0]          s1_page;
  logic [15:0]         s1_prod;

  logic        accept;
  logic        is_due;
  logic        keep;
  logic        big;
  logic [15:0] recip;
  logic [5:0]  quot;
  logic [5:0]  row;

  assign cfg_ready = 1'b1;
  assign full      = s1_valid && q_full;
  assign accept    = push && !full;
  assign q_push    = s1_valid && !q_full;

  assign is_due = ({1'b0, sample_index} == next_due_index) &&
                  (next_due_index < 9'(SAMPLE_COUNT)) &&
                  (plot_column < wpr_pkg::PLOT_COLUMNS);

  always_comb begin
    keep = 1'b0;
    case (operation)
      wpr_pkg::OP_START:  keep = 1'b1;
      wpr_pkg::OP_SAMPLE: keep = is_due;
      wpr_pkg::OP_READ:   keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  // product / 5 via reciprocal; anything at or above 200 clamps to the top row
  assign big   = (s1_prod >= 16'd200);
  assign recip = 16'(s1_prod[7:0]) * 16'd205;
  assign quot  = recip[15:10];
  assign row   = big ? wpr_pkg::TOP_ROW : (wpr_pkg::X_AXIS_ROW - quot);

  always_comb begin
    q_entry            = '0;
    q_entry.kind       = s1_kind;
    q_entry.flat       = s1_flat;
    q_entry.col        = s1_col;
    q_entry.row        = row;
    q_entry.prev_row   = previous_row;
    q_entry.prev_valid = previous_valid;
    q_entry.page       = s1_page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_step <= 8'd1;
      vertical_gain   <= 8'd1;
      sample_index    <= '0;
      next_due_index  <= '0;
      plot_column     <= '0;
      previous_row    <= '0;
      previous_valid  <= 1'b0;
      s1_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wpr_pkg::REG_HSTEP) horizontal_step <= cfg_data;
        if (cfg_index == wpr_pkg::REG_VGAIN) vertical_gain <= cfg_data;
      end

      if (accept) begin
        case (operation)
          wpr_pkg::OP_START: begin
            sample_index   <= '0;
            next_due_index <= '0;
            plot_column    <= '0;
          end
          wpr_pkg::OP_SAMPLE: begin
            sample_index <= sample_index + 8'd1;
            if (is_due) begin
              if (horizontal_step == 8'd0) begin
                plot_column <= wpr_pkg::PLOT_COLUMNS;
              end else begin
                plot_column    <= plot_column + 7'd1;
                next_due_index <= next_due_index + {1'b0, horizontal_step};
              end
            end
          end
          default: begin
          end
        endcase
      end

      // previous row follows plots in queue order
      if (q_push) begin
        if (s1_kind == wpr_pkg::CMD_CLEAR) begin
          previous_row   <= '0;
          previous_valid <= 1'b0;
        end else if (s1_kind == wpr_pkg::CMD_PLOT) begin
          previous_row   <= row;
          previous_valid <= 1'b1;
        end
      end

      if (accept && keep) s1_valid <= 1'b1;
      else if (q_push) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      s1_prod <= 16'(sample_value) * 16'(vertical_gain);
      s1_page <= page_select;
      s1_flat <= (horizontal_step == 8'd0);
      case (operation)
        wpr_pkg::OP_START: begin
          s1_kind <= wpr_pkg::CMD_CLEAR;
          s1_col  <= column_select;
        end
        wpr_pkg::OP_SAMPLE: begin
          s1_kind <= wpr_pkg::CMD_PLOT;
          s1_col  <= wpr_pkg::FIRST_PLOT_COL + plot_column;
        end
        default: begin
          s1_kind <= wpr_pkg::CMD_READ;
          s1_col  <= column_select;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpr_back.sv @@
// back end: executes queued commands against the column store, builds
// frame bytes with the axis overlay and buffers them; depends on wpr_pkg, wpr_fifo
`default_nettype none

module wpr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wpr_pkg::entry_t      q_entry,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           frame_byte
);

  localparam int OCW = $clog2(wpr_pkg::OUT_DEPTH + 1);

  logic [63:0]  column_store [wpr_pkg::SCREEN_WIDTH];
  logic [127:0] column_written;
  logic         flat_valid;
  logic [6:0]   flat_from;
  logic [5:0]   flat_row;

  logic         b2_valid;
  logic [63:0]  mem_q;
  logic [2:0]   b2_page;
  logic [6:0]   b2_col;
  logic         b2_written;
  logic         b2_flat_hit;
  logic [5:0]   b2_flat_row;

  logic [OCW-1:0] o_count;
  logic           o_full;
  logic           credit;
  logic           is_read;
  logic           is_plot;
  logic           is_clear;
  logic           flat_hit;
  logic [63:0]    mask;
  logic [63:0]    curve;
  logic [7:0]     out_byte;
  logic           unused_full;

  assign is_read  = (q_entry.kind == wpr_pkg::CMD_READ);
  assign is_plot  = (q_entry.kind == wpr_pkg::CMD_PLOT);
  assign is_clear = (q_entry.kind == wpr_pkg::CMD_CLEAR);

  // a read issues only with room reserved in the output buffer
  assign credit = ({1'b0, o_count} + (OCW + 1)'(b2_valid)) < (OCW + 1)'(wpr_pkg::OUT_DEPTH);
  assign q_pop  = !q_empty && (!is_read || credit);

  assign flat_hit = flat_valid && (q_entry.col >= flat_from) &&
                    (q_entry.col <= wpr_pkg::LAST_PLOT_COL);

  // new pixel plus rows strictly between it and the previous plotted row
  always_comb begin
    for (int r = 0; r < 64; r++) begin
      mask[r] = (6'(r) == q_entry.row) ||
                (q_entry.prev_valid &&
                 ((6'(r) > q_entry.row && 6'(r) < q_entry.prev_row) ||
                  (6'(r) < q_entry.row && 6'(r) > q_entry.prev_row)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_written <= '0;
      flat_valid     <= 1'b0;
      b2_valid       <= 1'b0;
    end else begin
      b2_valid <= q_pop && is_read;
      if (q_pop && is_clear) begin
        column_written <= '0;
        flat_valid     <= 1'b0;
      end
      if (q_pop && is_plot) begin
        column_written[q_entry.col] <= 1'b1;
        // zero step: remaining columns hold a single pixel at this row
        if (q_entry.flat) flat_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_plot) begin
      column_store[q_entry.col] <= mask;
      if (q_entry.flat) begin
        flat_from <= q_entry.col + 7'd1;
        flat_row  <= q_entry.row;
      end
    end
    if (q_pop && is_read) begin
      mem_q       <= column_store[q_entry.col];
      b2_page     <= q_entry.page;
      b2_col      <= q_entry.col;
      b2_written  <= column_written[q_entry.col];
      b2_flat_hit <= flat_hit;
      b2_flat_row <= flat_row;
    end
  end

  always_comb begin
    if (b2_written) curve = mem_q;
    else if (b2_flat_hit) curve = 64'd1 << b2_flat_row;
    else curve = '0;
    out_byte = wpr_pkg::overlay_byte(b2_page, b2_col);
    for (int i = 0; i < 8; i++) begin
      out_byte[7 - i] = out_byte[7 - i] | curve[{b2_page, 3'(i)}];
    end
  end

  wpr_fifo #(
    .WIDTH (8),
    .DEPTH (wpr_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (b2_valid),
    .wdata (out_byte),
    .pop   (pop),
    .rdata (frame_byte),
    .full  (o_full),
    .empty (empty),
    .count (o_count)
  );

  // space is reserved before a read issues, so o_full never blocks a push
  assign unused_full = o_full;

endmodule

`default_nettype wire

@@ hw/rtl/waveform_plot_rasterizer.sv @@
// waveform plot rasterizer top level: front end, command queue, back end
// depends on wpr_pkg, wpr_fifo, wpr_front, wpr_back
//
// usage:
//   input channel: drive operation and its fields with push; a transaction
//   is taken on a clock edge with push high and full low. start clears the
//   plot, sample plots one echo amplitude, read asks for one frame byte.
//   result channel: frame_byte is valid while empty is low and is taken on
//   an edge with pop high. only reads give a result, in input order.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is the horizontal step, index 1 the vertical gain. cfg_ready is always high.
// timing:
//   one transaction per clock sustained while full is low. a read result
//   reaches the output via the front register, the command queue, the
//   registered column store read and the result buffer. the column store has
//   one write and one read port; it serves one command per cycle unless stalled.
// reset: rst is synchronous; both queues empty, step and gain return to 1,
//   and the plot holds no curve.
// stalls: reads hold in the command queue while the four-entry result
//   buffer has no room; full rises once that queue is full and a command waits.
`default_nettype none

module waveform_plot_rasterizer #(
  parameter int SAMPLE_COUNT = wpr_pkg::SAMPLE_COUNT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] sample_value,
  input  wire logic [2:0] page_select,
  input  wire logic [6:0] column_select,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      frame_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int EW = $bits(wpr_pkg::entry_t);

  wpr_pkg::entry_t q_in;
  wpr_pkg::entry_t q_out;
  logic [EW-1:0]   q_out_bits;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  assign q_out = wpr_pkg::entry_t'(q_out_bits);

  wpr_front #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .sample_value  (sample_value),
    .page_select   (page_select),
    .column_select (column_select),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_push        (q_push),
    .q_entry       (q_in),
    .q_full        (q_full)
  );

  wpr_fifo #(
    .WIDTH (EW),
    .DEPTH (wpr_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .pop   (q_pop),
    .rdata (q_out_bits),
    .full  (q_full),
    .empty (q_empty),
    .count ()
  );

  wpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte)
  );

endmodule

`default_nettype wire

@@ tb/wpr_checker.sv @@
`timescale 1ns / 1ps
// wpr_checker: watches the config, input and result channels of the rasterizer,
// keeps its own copy of the plot and compares every frame byte; depends on wpr_pkg

module wpr_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] sample_value,
  input  wire logic [2:0] page_select,
  input  wire logic [6:0] column_select,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] frame_byte,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output int              failures,
  output int              outstanding,
  output int              checked
);

  localparam int AXIS_ROW      = 55;
  localparam int AXIS_COL      = 8;
  localparam int PLOT_TOP      = 15;
  localparam int PLOT_LEFT_COL = 10;
  localparam int NUM_COLS      = 112;
  localparam int MAX_INDEX     = 128;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] page;
    logic [6:0] col;
  } byte_read_t;

  logic [7:0]  step_reg;
  logic [7:0]  gain_reg;
  logic [63:0] curve_mem [128];
  logic        col_plotted [128];
  logic [5:0]  last_row;
  logic        last_valid;
  logic [7:0]  smp_idx;
  logic [8:0]  due_idx;
  logic [6:0]  plot_col;
  byte_read_t  read_fifo [$];

  // fixed axes, arrowheads and ticks drawn under the curve
  function automatic logic axis_pixel(int x, int y);
    int w;
    int h;
    if (y == AXIS_ROW) return 1'b1;
    if (x == AXIS_COL && y >= PLOT_TOP) return 1'b1;
    if (y >= 16 && y <= 20) begin
      w = (y - 16 < 2) ? 0 : (y - 16) / 2;
      if (x + w >= AXIS_COL && x <= AXIS_COL + w) return 1'b1;
    end
    if (x >= 123 && x <= 127) begin
      h = 127 - x;
      w = (h < 2) ? 0 : h / 2;
      if (y + w >= AXIS_ROW && y <= AXIS_ROW + w) return 1'b1;
    end
    if ((x == 35 || x == 62 || x == 89 || x == 116) && y >= AXIS_ROW - 2 && y <= AXIS_ROW)
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_plot();
    foreach (col_plotted[i]) col_plotted[i] = 1'b0;
    last_row   = '0;
    last_valid = 1'b0;
    smp_idx    = '0;
    due_idx    = '0;
    plot_col   = '0;
  endfunction

  // set the pixel and join it to the previous column's row
  function automatic void draw_column(logic [6:0] col, logic [5:0] row);
    logic [63:0] span;
    int lo;
    int hi;
    span = 64'd1 << row;
    if (last_valid) begin
      lo = (row < last_row) ? int'(row) : int'(last_row);
      hi = (row < last_row) ? int'(last_row) : int'(row);
      for (int r = lo + 1; r < hi; r++) span[r] = 1'b1;
    end
    curve_mem[col]   = span;
    col_plotted[col] = 1'b1;
    last_row         = row;
    last_valid       = 1'b1;
  endfunction

  function automatic void take_sample(logic [7:0] s);
    int q;
    logic [5:0] row;
    if ({1'b0, smp_idx} == due_idx && due_idx < 9'(MAX_INDEX) && plot_col < 7'(NUM_COLS)) begin
      q   = int'(s) * int'(gain_reg) / 5;
      row = (q >= AXIS_ROW - PLOT_TOP) ? 6'(PLOT_TOP) : 6'(AXIS_ROW - q);
      if (step_reg == 8'd0) begin
        // zero step: the first sample fills every remaining column
        while (plot_col < 7'(NUM_COLS)) begin
          draw_column(7'(PLOT_LEFT_COL) + plot_col, row);
          plot_col = plot_col + 7'd1;
        end
      end else begin
        draw_column(7'(PLOT_LEFT_COL) + plot_col, row);
        plot_col = plot_col + 7'd1;
        due_idx  = due_idx + {1'b0, step_reg};
      end
    end
    smp_idx = smp_idx + 8'd1;
  endfunction

  function automatic logic [7:0] frame_byte_model(logic [2:0] page, logic [6:0] col);
    logic [63:0] curve;
    logic [7:0]  bits;
    int y;
    curve = col_plotted[col] ? curve_mem[col] : '0;
    for (int b = 0; b < 8; b++) begin
      y = int'(page) * 8 + b;
      bits[7 - b] = curve[y] | axis_pixel(int'(col), y);
    end
    return bits;
  endfunction

  always @(posedge clk) begin : watch
    byte_read_t head;
    if (rst) begin
      step_reg = 8'd1;
      gain_reg = 8'd1;
      clear_plot();
      read_fifo.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (pop && !empty) begin
        if (read_fifo.size() == 0) begin
          failures++;
          $error("frame_byte %02h arrived with no read outstanding", frame_byte);
        end else begin
          head = read_fifo.pop_front();
          checked++;
          if (frame_byte !== head.value) begin
            failures++;
            $error("frame_byte mismatch at page %0d column %0d: expected %02h, actual %02h",
                   head.page, head.col, head.value, frame_byte);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpr_pkg::REG_HSTEP: step_reg = cfg_data;
          wpr_pkg::REG_VGAIN: gain_reg = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        case (operation)
          wpr_pkg::OP_START:  clear_plot();
          wpr_pkg::OP_SAMPLE: take_sample(sample_value);
          wpr_pkg::OP_READ: begin
            head.value = frame_byte_model(page_select, column_select);
            head.page  = page_select;
            head.col   = column_select;
            read_fifo.push_back(head);
          end
          default: ;
        endcase
      end
    end
    outstanding = read_fifo.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus and verdict for waveform_plot_rasterizer; directed frame, then
// random frames under several step/gain settings; depends on wpr_pkg, wpr_checker

module tb;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 72;
  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] operation;
  logic [7:0] sample_value;
  logic [2:0] page_select;
  logic [6:0] column_select;
  logic       empty;
  logic       pop;
  logic [7:0] frame_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int waiting_reads;
  int bytes_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;

  // -1 picks a random value
  int step_plan [PHASES] = '{5, 255, 0, 1, 2, 3, 1, -1};
  int gain_plan [PHASES] = '{1, 255, 7, 0, 12, 5, 255, -1};

  waveform_plot_rasterizer DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .sample_value(sample_value), .page_select(page_select), .column_select(column_select),
    .empty(empty), .pop(pop), .frame_byte(frame_byte), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wpr_checker plot_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .sample_value(sample_value), .page_select(page_select), .column_select(column_select),
    .empty(empty), .pop(pop), .frame_byte(frame_byte), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(fail_count), .outstanding(waiting_reads), .checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls at the current rate
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] value, logic [2:0] page,
                           logic [6:0] col);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push          = 1'b0;
      operation     = 2'($urandom);
      sample_value  = 8'($urandom);
      page_select   = 3'($urandom);
      column_select = 7'($urandom);
      @(negedge clk);
    end
    push          = 1'b1;
    operation     = op;
    sample_value  = value;
    page_select   = page;
    column_select = col;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op != OP_IGNORED) items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every read has come back and the command queue has drained
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (waiting_reads != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [6:0] pick_column();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 7'($urandom_range(10, 121));
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return 7'd8;
        1: return 7'($urandom_range(6, 10));
        2: return 7'(35 + 27 * $urandom_range(0, 3));
        3: return 7'($urandom_range(122, 127));
        default: return 7'($urandom_range(0, 9));
      endcase
    end
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 35) return 8'($urandom_range(0, 20));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int n;
    int r;
    int start_count;
    bit first_frame;
    logic [7:0] hstep_val;
    logic [7:0] gain_val;

    rst           = 1'b1;
    push          = 1'b0;
    operation     = wpr_pkg::OP_START;
    sample_value  = '0;
    page_select   = '0;
    column_select = '0;
    cfg_valid     = 1'b0;
    cfg_index     = wpr_pkg::REG_HSTEP;
    cfg_data      = '0;
    items_sent    = 0;
    send_idle_pct = 38;
    recv_idle_pct = 62;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // overlay only, nothing plotted yet
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd7, 7'd8);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd2, 7'd8);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd6, 7'd127);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd6, 7'd35);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd0, 7'd0);
    push_item(wpr_pkg::OP_START, 8'd0, 3'd0, 7'd0);
    // top clamp, bottom, then jumps that need vertical fill
    push_item(wpr_pkg::OP_SAMPLE, 8'd255, 3'd7, 7'd127);
    push_item(wpr_pkg::OP_SAMPLE, 8'd0, 3'd0, 7'd0);
    push_item(wpr_pkg::OP_SAMPLE, 8'd128, 3'd0, 7'd0);
    push_item(wpr_pkg::OP_SAMPLE, 8'd40, 3'd0, 7'd0);
    push_item(OP_IGNORED, 8'd255, 3'd7, 7'd127);
    push_item(wpr_pkg::OP_SAMPLE, 8'd0, 3'd0, 7'd0);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd1, 7'd10);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd2, 7'd11);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd6, 7'd11);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd3, 7'd12);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd5, 7'd13);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd6, 7'd14);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd7, 7'd127);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd4, 7'd121);
    push_item(wpr_pkg::OP_START, 8'd0, 3'd0, 7'd0);
    push_item(wpr_pkg::OP_READ, 8'd0, 3'd1, 7'd10);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 62;
      end else if (phase < 6) begin
        send_idle_pct = 62;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      hstep_val = (step_plan[phase] < 0) ? 8'($urandom) : 8'(step_plan[phase]);
      gain_val  = (gain_plan[phase] < 0) ? 8'($urandom) : 8'(gain_plan[phase]);
      write_reg(wpr_pkg::REG_HSTEP, hstep_val);
      write_reg(wpr_pkg::REG_VGAIN, gain_val);
      // unused register indexes must leave the plot alone
      if ($urandom_range(0, 1) == 1) write_reg(2'($urandom_range(2, 3)), 8'($urandom));

      start_count = items_sent;
      first_frame = 1'b1;
      while (items_sent - start_count < PHASE_ITEMS) begin
        // sometimes keep the old frame going under the new settings
        if (!(first_frame && $urandom_range(0, 99) < 30))
          push_item(wpr_pkg::OP_START, 8'($urandom), 3'($urandom), 7'($urandom));
        first_frame = 1'b0;
        n = ($urandom_range(0, 99) < 5) ? $urandom_range(250, 300) : $urandom_range(0, 130);
        for (int i = 0; i < n && items_sent - start_count < PHASE_ITEMS; i++) begin
          r = $urandom_range(0, 99);
          if (r < 12)
            push_item(wpr_pkg::OP_READ, 8'($urandom), 3'($urandom), pick_column());
          else if (r < 14)
            push_item(OP_IGNORED, 8'($urandom), 3'($urandom), 7'($urandom));
          else if (r < 15)
            push_item(wpr_pkg::OP_START, 8'($urandom), 3'($urandom), 7'($urandom));
          else
            push_item(wpr_pkg::OP_SAMPLE, pick_sample(), 3'($urandom), 7'($urandom));
        end
        repeat ($urandom_range(4, 24))
          push_item(wpr_pkg::OP_READ, 8'($urandom), 3'($urandom), pick_column());
      end
      settle();
    end

    $display("covered %0d start, sample and read transactions over %0d step/gain settings",
             items_sent, PHASES + 1);
    $display("%0d frame bytes compared under mixed input gaps and output stalls",
             bytes_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
